@@ rtl/tach_speed_bang_bang_control_top_macros.svh @@
// Assertion macros shared by the tachometer speed control RTL.
`ifndef TACH_SPEED_BANG_BANG_CONTROL_TOP_MACROS_SVH
`define TACH_SPEED_BANG_BANG_CONTROL_TOP_MACROS_SVH

// Check an invariant on every clock edge outside reset.
`define TSBB_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define TSBB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define TSBB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tsbb_pkg.sv @@
// Types, constants and the mode table of the tachometer speed control block.
`default_nettype none
package tsbb_pkg;

	localparam int unsigned MODE_W    = 3;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned SPEED_W   = 18;
	localparam int unsigned ERR_W     = 14;
	localparam int unsigned PWR_W     = 7;
	localparam int unsigned TARGET_W  = 12;

	// 1000 ms per second times 30 (60 s per minute over two slots per turn)
	localparam int unsigned SPEED_SCALE = 30000;

	localparam logic [SPEED_W-1:0] SPEED_MAX  = '1;
	localparam logic [ERR_W-1:0]   ERR_MAX    = '1;
	localparam logic [PWR_W-1:0]   FULL_POWER = 7'd127;

	// Divide by ten as a multiply by ceil(2^21 / 10) and a right shift by 21;
	// exact for every 18-bit dividend.
	localparam logic [SPEED_W-1:0] ERR_RECIP = 18'd209716;
	localparam int unsigned        ERR_SHIFT = 21;

	localparam logic [MODE_W-1:0] MODE_LONG  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MID   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SHORT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ALT   = 3'd5;

	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [PWR_W-1:0]    base;
	} mode_set_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_SPEED_DIV,
		S_CTRL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic tick;
		logic start_speed_div;
		logic speed_wb;
		logic ctrl_update;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic measure;
		logic div_busy;
		logic out_free;
	} sts_t;

	function automatic mode_set_t mode_lookup(input logic [MODE_W-1:0] mode);
		mode_set_t m;
		case (mode)
			MODE_LONG:  m = '{target: 12'd2800, base: 7'd38};
			MODE_MID:   m = '{target: 12'd2400, base: 7'd30};
			MODE_SHORT: m = '{target: 12'd2100, base: 7'd20};
			MODE_ALT:   m = '{target: 12'd2300, base: 7'd30};
			default:    m = '{target: 12'd0,    base: 7'd0};
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

@@ rtl/tach_speed_bang_bang_control_top.sv @@
// Top level of the flywheel tachometer speed measurement and bang-bang drive block.
`default_nettype none
// Each input request is one 1 ms tick carrying the sampled tachometer level
// (0 = slot present). Every tick yields exactly one result request with the
// motor drive level, the measured speed in rpm and |target - speed| / 10.
// A falling edge of the level counts a pulse; after PULSES_PER_MEASURE pulses
// the speed is (30000 * PULSES_PER_MEASURE) / elapsed ms, and it reads zero
// once more than TIMEOUT_TICKS ms pass without a measurement. The user must
// write shooting_mode through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce this. The mode picks the target speed and base
// power. One tick at a time is processed. A tick without a measurement passes
// through the tick, decision and output states; a tick that completes a
// measurement also runs a restoring divider of W bits, one quotient bit per
// cycle, where W is the larger of 18 and the width of 30000 * PULSES_PER_MEASURE
// (18 bits at the default of five pulses). The divide by ten is a combinational
// reciprocal multiply. The output register lets the next tick be accepted
// while a result still waits; a tick stalls in its last state only while the
// previous result is still unaccepted.
module tach_speed_bang_bang_control_top #(
	parameter int unsigned PULSES_PER_MEASURE = 5,
	parameter int unsigned TIMEOUT_TICKS      = 500
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        tach_level,
	input  wire logic                        cfg_we,
	input  wire logic [tsbb_pkg::MODE_W-1:0] cfg_wdata,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tsbb_pkg::PWR_W-1:0]       motor_power,
	output logic [tsbb_pkg::SPEED_W-1:0]     measured_speed,
	output logic [tsbb_pkg::ERR_W-1:0]       speed_error
);
	import tsbb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each tick: update counters, divide when a measurement completes, decide, publish.
	tsbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold all measurement state, the mode register and the result register.
	tsbb_datapath #(
		.PULSES_PER_MEASURE (PULSES_PER_MEASURE),
		.TIMEOUT_TICKS      (TIMEOUT_TICKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.tach_level     (tach_level),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.motor_power    (motor_power),
		.measured_speed (measured_speed),
		.speed_error    (speed_error)
	);

endmodule
`default_nettype wire

@@ rtl/tsbb_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tsbb_div #(
	parameter int unsigned W  = 19,
	parameter int unsigned DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [W-1:0]  dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic [W-1:0]       quotient
);
	localparam int unsigned CNT_W = $clog2(W + 1);

	logic [W-1:0]     quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW:0]      shifted;
	logic [DW:0]      trial;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/tsbb_datapath.sv @@
// Datapath: tick counters, edge detection, speed and drive registers, output register.
`default_nettype none
module tsbb_datapath #(
	parameter int unsigned PULSES_PER_MEASURE = 5,
	parameter int unsigned TIMEOUT_TICKS      = 500
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tsbb_pkg::cmd_t              cmd,
	output tsbb_pkg::sts_t                   sts,
	input  wire logic                        tach_level,
	input  wire logic                        cfg_we,
	input  wire logic [tsbb_pkg::MODE_W-1:0] cfg_wdata,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tsbb_pkg::PWR_W-1:0]       motor_power,
	output logic [tsbb_pkg::SPEED_W-1:0]     measured_speed,
	output logic [tsbb_pkg::ERR_W-1:0]       speed_error
);
	import tsbb_pkg::*;
	`include "tach_speed_bang_bang_control_top_macros.svh"

	localparam int unsigned SPEED_NUM = SPEED_SCALE * PULSES_PER_MEASURE;
	localparam int unsigned NUM_W     = $clog2(SPEED_NUM + 1);
	localparam int unsigned DIV_W     = (NUM_W > SPEED_W) ? NUM_W : SPEED_W;
	localparam int unsigned PC_W      = $clog2(PULSES_PER_MEASURE + 1);
	localparam int unsigned PROD_W    = 2 * SPEED_W;
	localparam int unsigned ERR_Q_W   = PROD_W - ERR_SHIFT;

	logic [MODE_W-1:0]    mode_q;
	logic [PC_W-1:0]      pulse_count_q;
	logic                 armed_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [PWR_W-1:0]     drive_q;
	logic [SPEED_W-1:0]   diff_q;
	logic                 measure_q;
	logic                 out_valid_q;
	logic [PWR_W-1:0]     power_out_q;
	logic [SPEED_W-1:0]   speed_out_q;
	logic [ERR_W-1:0]     err_out_q;

	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [PC_W-1:0]      pc_next;
	logic                 armed_next;
	logic [SPEED_W-1:0]   speed_eff;
	logic [SPEED_W-1:0]   target_ext;
	mode_set_t            mset;
	logic                 div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [ELAPSED_W-1:0] div_divisor;
	logic                 div_busy;
	logic [DIV_W-1:0]     div_quo;
	logic [SPEED_W-1:0]   speed_sat;
	logic [PROD_W-1:0]    err_prod;
	logic [ERR_Q_W-1:0]   err_quo;
	logic [ERR_W-1:0]     err_sat;

	// Tick update: saturating millisecond count and falling-edge pulse count.
	always_comb begin
		elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		pc_next     = pulse_count_q;
		armed_next  = armed_q;
		if (!tach_level) begin
			if (!armed_q) begin
				pc_next    = pulse_count_q + 1'b1;
				armed_next = 1'b1;
			end
		end else begin
			armed_next = 1'b0;
		end
	end

	// Timeout and target lookup for the bang-bang decision.
	always_comb begin
		mset       = mode_lookup(mode_q);
		target_ext = SPEED_W'(mset.target);
		speed_eff  = (elapsed_q > ELAPSED_W'(TIMEOUT_TICKS)) ? '0 : speed_q;
	end

	// Divide the fixed numerator by the elapsed count.
	assign div_start    = cmd.start_speed_div;
	assign div_dividend = DIV_W'(SPEED_NUM);
	assign div_divisor  = elapsed_q;

	tsbb_div #(
		.W  (DIV_W),
		.DW (ELAPSED_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign speed_sat = (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPEED_W-1:0];

	// Scale the registered difference by a tenth with a reciprocal multiply.
	assign err_prod = PROD_W'(diff_q) * PROD_W'(ERR_RECIP);
	assign err_quo  = err_prod[PROD_W-1:ERR_SHIFT];
	assign err_sat  = (err_quo > ERR_Q_W'(ERR_MAX)) ? ERR_MAX : err_quo[ERR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= '0;
			pulse_count_q <= '0;
			armed_q       <= 1'b0;
			elapsed_q     <= '0;
			speed_q       <= '0;
			drive_q       <= '0;
			measure_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.tick) begin
				elapsed_q     <= elapsed_inc;
				pulse_count_q <= pc_next;
				armed_q       <= armed_next;
				measure_q     <= (pc_next >= PC_W'(PULSES_PER_MEASURE));
			end
			if (cmd.speed_wb) begin
				speed_q       <= speed_sat;
				elapsed_q     <= '0;
				pulse_count_q <= '0;
			end
			if (cmd.ctrl_update) begin
				speed_q <= speed_eff;
				if (speed_eff > target_ext) begin
					drive_q <= mset.base;
				end else if (speed_eff < target_ext) begin
					drive_q <= FULL_POWER;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ctrl_update) begin
			diff_q <= (target_ext >= speed_eff) ? target_ext - speed_eff
				: speed_eff - target_ext;
		end
		if (cmd.load_out) begin
			power_out_q <= drive_q;
			speed_out_q <= speed_q;
			err_out_q   <= err_sat;
		end
	end

	assign sts.measure  = measure_q;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign motor_power    = power_out_q;
	assign measured_speed = speed_out_q;
	assign speed_error    = err_out_q;

	`TSBB_ASSERT_ALWAYS(a_pulse_bound, pulse_count_q <= PC_W'(PULSES_PER_MEASURE), "pulse count overran")
	`TSBB_ASSERT_NXT(a_drive_hold, !cmd.ctrl_update, $stable(drive_q), "drive changed outside decision")

endmodule
`default_nettype wire

@@ rtl/tsbb_ctrl.sv @@
// Controller state machine sequencing one tick request through the datapath.
`default_nettype none
module tsbb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tsbb_pkg::sts_t sts,
	output tsbb_pkg::cmd_t      cmd
);
	import tsbb_pkg::*;
	`include "tach_speed_bang_bang_control_top_macros.svh"

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_TICK;
			S_TICK:      state_d = sts.measure ? S_SPEED_DIV : S_CTRL;
			S_SPEED_DIV: if (!sts.div_busy) state_d = S_CTRL;
			S_CTRL:      state_d = S_OUT;
			S_OUT:       if (sts.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.tick = in_valid;
			end
			S_TICK:      cmd.start_speed_div = sts.measure;
			S_SPEED_DIV: cmd.speed_wb = !sts.div_busy;
			S_CTRL:      cmd.ctrl_update = 1'b1;
			S_OUT:       cmd.load_out = sts.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	`TSBB_ASSERT_IMP(a_idle_div_quiet, state_q == S_IDLE, !sts.div_busy, "divider busy while idle")
	`TSBB_ASSERT_NXT(a_out_to_idle, cmd.load_out, state_q == S_IDLE, "no return to idle after result")

endmodule
`default_nettype wire

@@ dv/tach_speed_bang_bang_control_top_test.sv @@
// Self-checking testbench for the tachometer speed measurement and bang-bang drive block.
`default_nettype none
module tach_speed_bang_bang_control_top_test;
	import tsbb_pkg::*;

	// Measurement setup of the block under test.
	localparam int unsigned PULSES        = 5;
	localparam int unsigned TIMEOUT_MS    = 500;
	localparam int unsigned RPM_NUMERATOR = SPEED_SCALE * PULSES;

	// Shooting modes with no target; the active ones come from the package.
	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SPARE4 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	// Run shape: about 1500 ticks in all.
	localparam int unsigned RANDOM_TICKS    = 950;
	localparam int unsigned TIMEOUT_STRETCH = 505;
	localparam int unsigned SETTLE_CYCLES   = 100;
	localparam int unsigned RUN_LIMIT       = 4_000_000;

	// One result request as the block presents it.
	typedef struct packed {
		logic [PWR_W-1:0]   power;
		logic [SPEED_W-1:0] speed;
		logic [ERR_W-1:0]   error;
	} speed_report_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                tach_level;
	logic                cfg_we;
	logic [MODE_W-1:0]   cfg_wdata;
	logic                out_valid;
	logic                out_ready;
	logic [PWR_W-1:0]    motor_power;
	logic [SPEED_W-1:0]  measured_speed;
	logic [ERR_W-1:0]    speed_error;

	// Predicted flywheel state, mirrored from the block's behavior.
	logic [MODE_W-1:0]    fly_mode;
	logic [ELAPSED_W-1:0] fly_ms;
	int unsigned          fly_slots;
	logic                 fly_wait_high;
	logic [SPEED_W-1:0]   fly_rpm;
	logic [PWR_W-1:0]     fly_drive;

	speed_report_t expected_reports[$];
	int unsigned   ticks_sent;
	int unsigned   faults;
	int unsigned   cycle_count;
	int unsigned   stall_left;
	bit            tx_idle;
	bit            rx_idle;

	tach_speed_bang_bang_control_top #(
		.PULSES_PER_MEASURE(PULSES),
		.TIMEOUT_TICKS(TIMEOUT_MS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tach_level(tach_level),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.motor_power(motor_power),
		.measured_speed(measured_speed),
		.speed_error(speed_error)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Gap length: mostly short, now and then longer, and rarely long enough
	// to cover a whole measurement tick.
	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	// Advance the predicted flywheel by one 1 ms tick and form its report.
	// Order inside a tick: count time, examine the edge, finish a measurement,
	// apply the timeout, then decide the drive.
	function automatic speed_report_t advance_flywheel(input logic level);
		speed_report_t       rep;
		logic [TARGET_W-1:0] target;
		logic [PWR_W-1:0]    base;
		int unsigned         quotient;
		int unsigned         rpm_gap;
		int unsigned         err;
		if (fly_ms != '1)
			fly_ms = fly_ms + 1'b1;
		// A falling edge counts once; the level must return high to re-arm.
		if (level == 1'b0) begin
			if (!fly_wait_high) begin
				fly_slots++;
				fly_wait_high = 1'b1;
			end
		end else begin
			fly_wait_high = 1'b0;
		end
		if (fly_slots >= PULSES) begin
			quotient  = (fly_ms != '0) ? RPM_NUMERATOR / fly_ms : 0;
			fly_rpm   = (quotient > SPEED_MAX) ? SPEED_MAX : quotient[SPEED_W-1:0];
			fly_ms    = '0;
			fly_slots = 0;
		end
		if (fly_ms > TIMEOUT_MS)
			fly_rpm = '0;
		case (fly_mode)
			MODE_LONG: begin
				target = 12'd2800;
				base   = 7'd38;
			end
			MODE_MID: begin
				target = 12'd2400;
				base   = 7'd30;
			end
			MODE_SHORT: begin
				target = 12'd2100;
				base   = 7'd20;
			end
			MODE_ALT: begin
				target = 12'd2300;
				base   = 7'd30;
			end
			default: begin
				target = '0;
				base   = '0;
			end
		endcase
		// Bang-bang: base power above target, full power below, hold on a tie.
		if (fly_rpm > target)
			fly_drive = base;
		else if (fly_rpm < target)
			fly_drive = FULL_POWER;
		rpm_gap = (target >= fly_rpm) ? target - fly_rpm : fly_rpm - target;
		err     = rpm_gap / 10;
		if (err > ERR_MAX)
			err = ERR_MAX;
		rep.power = fly_drive;
		rep.speed = fly_rpm;
		rep.error = err[ERR_W-1:0];
		return rep;
	endfunction

	// Send one tick request. Callers stand at a rising edge; valid is dropped
	// only when a gap follows, so it never falls and rises in the same step.
	task automatic send_tick(input logic level);
		int unsigned gap;
		gap = (tx_idle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		tach_level <= level;
		do @(posedge clk); while (!in_ready);
		expected_reports.push_back(advance_flywheel(level));
		ticks_sent++;
	endtask

	// Drop valid and wait until every predicted report has come back.
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// Write the shooting mode while the block is idle.
	task automatic load_shooting_mode(input logic [MODE_W-1:0] mode);
		drain_requests();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we   <= 1'b0;
		fly_mode  = mode;
	endtask

	task automatic send_pulse_train(input int unsigned low_ms, input int unsigned high_ms,
			input int unsigned pulses);
		repeat (pulses) begin
			repeat (low_ms) send_tick(1'b0);
			repeat (high_ms) send_tick(1'b1);
		end
	endtask

	// Off mode straight after reset: speed zero equals target zero, so the
	// drive holds its reset value.
	task automatic test_reset_state();
		load_shooting_mode(MODE_OFF);
		repeat (2) send_tick(1'b1);
	endtask

	// Full power below target, then a switch to an unused mode with speed zero
	// must keep full power rather than fall to base.
	task automatic test_tie_holds_drive();
		load_shooting_mode(MODE_LONG);
		send_tick(1'b1);
		load_shooting_mode(MODE_SPARE4);
		send_tick(1'b1);
	endtask

	// Shortest possible measurement: alternate the level on every tick until the pulse count reaches PULSES.
	task automatic test_fastest_measure();
		load_shooting_mode(MODE_MID);
		send_pulse_train(1, 1, PULSES);
	endtask

	// Unused modes with a nonzero speed drive base power zero.
	task automatic test_unused_modes();
		load_shooting_mode(MODE_SPARE7);
		repeat (2) send_tick(1'b0);
		load_shooting_mode(MODE_SPARE6);
		send_tick(1'b1);
	endtask

	// Hold the level high past the timeout so the speed reads zero.
	task automatic test_timeout();
		load_shooting_mode(MODE_SHORT);
		repeat (TIMEOUT_STRETCH) send_tick(1'b1);
	endtask

	// Mostly well-formed pulse trains with random periods, some of them near
	// the targets, plus trains cut short, some into a timeout, and plain noise.
	task automatic test_random_mix();
		int unsigned stop_at;
		int unsigned roll;
		int unsigned period_ms;
		int unsigned low_ms;
		stop_at = ticks_sent + RANDOM_TICKS;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(0, 2) == 0)
				load_shooting_mode(3'($urandom_range(0, 7)));
			tx_idle = ($urandom_range(0, 4) != 0);
			rx_idle = ($urandom_range(0, 4) != 0);
			roll = $urandom_range(0, 99);
			roll = (roll < 70) ? 0 : (roll < 85) ? 1 : 2;
			if (roll == 0 || roll == 1) begin
				period_ms = $urandom_range(0, 99);
				if (period_ms < 60)
					period_ms = $urandom_range(9, 16);
				else if (period_ms < 92)
					period_ms = $urandom_range(2, 30);
				else
					period_ms = $urandom_range(40, 120);
				low_ms = $urandom_range(1, period_ms - 1);
			end
			if (roll == 0) begin
				send_pulse_train(low_ms, period_ms - low_ms, $urandom_range(3, 8));
			end else if (roll == 1) begin
				// Break the train off and let the level sit high, either
				// briefly or across the timeout.
				send_pulse_train(low_ms, period_ms - low_ms, $urandom_range(1, PULSES - 1));
				if ($urandom_range(0, 1) == 0)
					repeat ($urandom_range(10, 60)) send_tick(1'b1);
				else
					repeat ($urandom_range(480, 560)) send_tick(1'b1);
			end else begin
				repeat ($urandom_range(5, 40)) send_tick(1'($urandom_range(0, 1)));
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Stall the result side in random bursts while rx_idle is set.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (rx_idle && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	// Compare each accepted result request with the oldest prediction.
	always @(posedge clk) begin
		speed_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result: motor_power %0d measured_speed %0d speed_error %0d",
					motor_power, measured_speed, speed_error);
				faults++;
			end else begin
				want = expected_reports.pop_front();
				if (motor_power !== want.power) begin
					$error("motor_power: expected %0d, got %0d", want.power, motor_power);
					faults++;
				end
				if (measured_speed !== want.speed) begin
					$error("measured_speed: expected %0d, got %0d", want.speed, measured_speed);
					faults++;
				end
				if (speed_error !== want.error) begin
					$error("speed_error: expected %0d, got %0d", want.error, speed_error);
					faults++;
				end
			end
		end
	end

	// Abort a hung run.
	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		tach_level    = 1'b1;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		out_ready     = 1'b1;
		stall_left    = 0;
		tx_idle       = 1'b1;
		rx_idle       = 1'b1;
		ticks_sent    = 0;
		faults        = 0;
		cycle_count   = 0;
		fly_mode      = MODE_OFF;
		fly_ms        = '0;
		fly_slots     = 0;
		fly_wait_high = 1'b0;
		fly_rpm       = '0;
		fly_drive     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_tie_holds_drive();
		test_fastest_measure();
		test_unused_modes();
		test_timeout();
		test_random_mix();

		// Let any stray result show up before the verdict.
		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/tsbb_pkg.sv
rtl/tsbb_div.sv
rtl/tsbb_datapath.sv
rtl/tsbb_ctrl.sv
rtl/tach_speed_bang_bang_control_top.sv
dv/tach_speed_bang_bang_control_top_test.sv
